// ===== rtl/frcm_pkg.sv =====
package frcm_pkg;

	localparam int unsigned FIELD_COORD_BITS = 12;
	localparam int unsigned SLOT_BITS        = 3;
	localparam int unsigned CHAN_BITS        = 8;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_PIXEL = 1'b1;

	localparam logic [CHAN_BITS-1:0] GREY_TOP = 8'd255;

	typedef struct packed {
		logic                        operation;
		logic [SLOT_BITS-1:0]        slot;
		logic [FIELD_COORD_BITS-1:0] rect_left;
		logic [FIELD_COORD_BITS-1:0] rect_top;
		logic [FIELD_COORD_BITS-1:0] rect_width;
		logic [FIELD_COORD_BITS-1:0] rect_height;
		logic                        entry_valid;
		logic [FIELD_COORD_BITS-1:0] pixel_row;
		logic [FIELD_COORD_BITS-1:0] pixel_col;
		logic [CHAN_BITS-1:0]        in_blue;
		logic [CHAN_BITS-1:0]        in_green;
		logic [CHAN_BITS-1:0]        in_red;
	} frcm_in_t;

	typedef struct packed {
		logic [CHAN_BITS-1:0] out_blue;
		logic [CHAN_BITS-1:0] out_green;
		logic [CHAN_BITS-1:0] out_red;
		logic                 inside_face;
	} frcm_out_t;

endpackage

// ===== rtl/frcm_rect_table.sv =====
module frcm_rect_table #(
	parameter int unsigned MAX_RECTS  = 8,
	parameter int unsigned COORD_BITS = 12
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     wr_en,
	input  frcm_pkg::frcm_in_t                       item,
	input  logic [frcm_pkg::FIELD_COORD_BITS-1:0]    min_width,
	output logic                                     hit
);

	localparam int unsigned EXT_BITS = 16;
	localparam int unsigned SUM_BITS = COORD_BITS + 1;

	logic [EXT_BITS-1:0]   left_x, top_x, width_x, height_x, row_x, col_x;
	logic [COORD_BITS-1:0] wr_left, wr_top, wr_width, wr_height, row_c, col_c;

	logic [COORD_BITS-1:0] left_q   [MAX_RECTS];
	logic [COORD_BITS-1:0] top_q    [MAX_RECTS];
	logic [COORD_BITS-1:0] width_q  [MAX_RECTS];
	logic [COORD_BITS-1:0] height_q [MAX_RECTS];
	logic [MAX_RECTS-1:0]  valid_q;
	logic [MAX_RECTS-1:0]  hit_vec;

	// mask or widen the fixed-width fields to the table's coordinate width
	assign left_x   = EXT_BITS'(item.rect_left);
	assign top_x    = EXT_BITS'(item.rect_top);
	assign width_x  = EXT_BITS'(item.rect_width);
	assign height_x = EXT_BITS'(item.rect_height);
	assign row_x    = EXT_BITS'(item.pixel_row);
	assign col_x    = EXT_BITS'(item.pixel_col);

	assign wr_left   = left_x[COORD_BITS-1:0];
	assign wr_top    = top_x[COORD_BITS-1:0];
	assign wr_width  = width_x[COORD_BITS-1:0];
	assign wr_height = height_x[COORD_BITS-1:0];
	assign row_c     = row_x[COORD_BITS-1:0];
	assign col_c     = col_x[COORD_BITS-1:0];

	for (genvar k = 0; k < MAX_RECTS; k++) begin : g_entry
		logic                sel;
		logic [SUM_BITS-1:0] right, bottom;

		assign sel = wr_en && (7'(item.slot) == 7'(k));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_q[k] <= 1'b0;
			end else if (sel) begin
				valid_q[k] <= item.entry_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (sel) begin
				left_q[k]   <= wr_left;
				top_q[k]    <= wr_top;
				width_q[k]  <= wr_width;
				height_q[k] <= wr_height;
			end
		end

		assign right  = SUM_BITS'(left_q[k]) + SUM_BITS'(width_q[k]);
		assign bottom = SUM_BITS'(top_q[k]) + SUM_BITS'(height_q[k]);

		assign hit_vec[k] = valid_q[k]
			&& (17'(width_q[k]) > 17'(min_width))
			&& (row_c >= top_q[k]) && (SUM_BITS'(row_c) <= bottom)
			&& (col_c >= left_q[k]) && (SUM_BITS'(col_c) <= right);
	end

	assign hit = |hit_vec;

endmodule

// ===== rtl/frcm_colour.sv =====
module frcm_colour (
	input  frcm_pkg::frcm_in_t  pix,
	input  logic                hit,
	output frcm_pkg::frcm_out_t res
);

	logic [frcm_pkg::CHAN_BITS-1:0] grey;

	assign grey = frcm_pkg::GREY_TOP - pix.in_green;

	always_comb begin
		if (hit) begin
			res.out_blue  = pix.in_blue;
			res.out_green = pix.in_green;
			res.out_red   = pix.in_red;
		end else begin
			res.out_blue  = grey;
			res.out_green = grey;
			res.out_red   = grey;
		end
		res.inside_face = hit;
	end

endmodule

// ===== rtl/face_region_colour_mask_top.sv =====
// Face region colour mask. Takes one beat per clock on the input channel while in_stall is
// low. A rectangle write beat (operation 0) fills one of MAX_RECTS table entries and gives
// no result; it is seen by every beat accepted after it. A pixel beat (operation 1) gives
// one result beat through the input register and the result register: the colour unchanged
// if the pixel lies inside any valid rectangle wider than min_width, edges included,
// otherwise all three channels set to 255 minus green. All entries are compared
// in parallel between the two registers, so the sustained rate is one beat per clock while
// out_stall is low. The input register holds one more beat while the result register
// waits. Reset leaves every entry invalid and min_width at 0; cfg_ready is always high and
// min_width should only be written while no beat is in flight.
module face_region_colour_mask_top #(
	parameter int unsigned MAX_RECTS  = 8,
	parameter int unsigned COORD_BITS = 12
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  frcm_pkg::frcm_in_t                    in_data,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output frcm_pkg::frcm_out_t                   out_data,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [frcm_pkg::FIELD_COORD_BITS-1:0] cfg_data
);

	logic                                  valid_s1, valid_s2;
	frcm_pkg::frcm_in_t                    item_s1;
	frcm_pkg::frcm_out_t                   res_s2;
	frcm_pkg::frcm_out_t                   res;
	logic [frcm_pkg::FIELD_COORD_BITS-1:0] min_width_q;
	logic                                  in_acc, s1_leave, s2_en, s2_load, wr_en, hit;

	assign cfg_ready = 1'b1;

	assign s2_en    = !valid_s2 || !out_stall;
	assign s1_leave = valid_s1 && (item_s1.operation == frcm_pkg::OP_WRITE || s2_en);
	assign in_stall = valid_s1 && !s1_leave;
	assign in_acc   = in_valid && !in_stall;
	assign wr_en    = valid_s1 && item_s1.operation == frcm_pkg::OP_WRITE;
	assign s2_load  = valid_s1 && item_s1.operation == frcm_pkg::OP_PIXEL && s2_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_width_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			min_width_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_leave) begin
				valid_s1 <= 1'b0;
			end
			if (s2_en) begin
				valid_s2 <= s2_load;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1 <= in_data;
		end
		if (s2_load) begin
			res_s2 <= res;
		end
	end

	frcm_rect_table #(
		.MAX_RECTS  (MAX_RECTS),
		.COORD_BITS (COORD_BITS)
	) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.item      (item_s1),
		.min_width (min_width_q),
		.hit       (hit)
	);

	frcm_colour u_colour (
		.pix (item_s1),
		.hit (hit),
		.res (res)
	);

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

	// grey results carry one value on all three channels
	a_grey_equal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.inside_face |->
			out_data.out_blue == out_data.out_green && out_data.out_green == out_data.out_red)
		else $error("grey result with unequal channels");

	// a new result beat only follows a pixel beat in the input register
	a_pixel_only: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(valid_s1 && item_s1.operation == frcm_pkg::OP_PIXEL))
		else $error("result beat without a pixel beat");

	// stall only with the input register full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && item_s1.operation == frcm_pkg::OP_PIXEL && valid_s2)
		else $error("input stalled without cause");

endmodule

// ===== bench/frcm_checker.sv =====
module frcm_checker
	import frcm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_stall,
	input  frcm_in_t  in_data,
	input  logic      out_valid,
	input  logic      out_stall,
	input  frcm_out_t out_data,
	input  logic      cfg_valid,
	input  logic      cfg_ready,
	input  logic [FIELD_COORD_BITS-1:0] cfg_data,
	output int        fail_count,
	output int        pending
);

	localparam int NUM_BOXES = 8;

	typedef struct packed {
		logic [FIELD_COORD_BITS-1:0] left;
		logic [FIELD_COORD_BITS-1:0] top;
		logic [FIELD_COORD_BITS-1:0] width;
		logic [FIELD_COORD_BITS-1:0] height;
		logic                        live;
	} face_box_t;

	face_box_t                   boxes [NUM_BOXES];
	logic [FIELD_COORD_BITS-1:0] min_width;
	frcm_out_t                   masked_q [$];

	function automatic frcm_out_t mask_pixel(frcm_in_t px);
		frcm_out_t                 res;
		logic                      hit;
		logic [FIELD_COORD_BITS:0] right;
		logic [FIELD_COORD_BITS:0] bottom;
		logic [CHAN_BITS-1:0]      grey;
		int                        k;
		hit = 1'b0;
		for (k = 0; k < NUM_BOXES; k++) begin
			if (boxes[k].live && boxes[k].width > min_width) begin
				right  = {1'b0, boxes[k].left} + {1'b0, boxes[k].width};
				bottom = {1'b0, boxes[k].top} + {1'b0, boxes[k].height};
				if (px.pixel_row >= boxes[k].top && {1'b0, px.pixel_row} <= bottom &&
				    px.pixel_col >= boxes[k].left && {1'b0, px.pixel_col} <= right)
					hit = 1'b1;
			end
		end
		if (hit) begin
			res.out_blue    = px.in_blue;
			res.out_green   = px.in_green;
			res.out_red     = px.in_red;
			res.inside_face = 1'b1;
		end else begin
			grey            = GREY_TOP - px.in_green;
			res.out_blue    = grey;
			res.out_green   = grey;
			res.out_red     = grey;
			res.inside_face = 1'b0;
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		frcm_out_t want;
		int        k;
		if (!arst_n) begin
			for (k = 0; k < NUM_BOXES; k++)
				boxes[k] = '0;
			min_width  = '0;
			masked_q.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				min_width = cfg_data;
			if (out_valid && !out_stall) begin
				if (masked_q.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result beat, expected none actual %h",
						$time, out_data);
				end else begin
					want = masked_q.pop_front();
					if (out_data.out_blue !== want.out_blue ||
					    out_data.out_green !== want.out_green ||
					    out_data.out_red !== want.out_red ||
					    out_data.inside_face !== want.inside_face) begin
						fail_count++;
						$display("%0t: result mismatch, expected b=%h g=%h r=%h in=%b actual b=%h g=%h r=%h in=%b",
							$time, want.out_blue, want.out_green, want.out_red,
							want.inside_face, out_data.out_blue, out_data.out_green,
							out_data.out_red, out_data.inside_face);
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (in_data.operation == OP_PIXEL)
					masked_q.push_back(mask_pixel(in_data));
				else
					boxes[in_data.slot] = '{in_data.rect_left, in_data.rect_top,
						in_data.rect_width, in_data.rect_height, in_data.entry_valid};
			end
			pending = masked_q.size();
		end
	end

endmodule

// ===== bench/tb_top.sv =====
module tb_top;

	import frcm_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_BEATS = 310;

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_stall;
	frcm_in_t                    in_data;
	logic                        out_valid;
	logic                        out_stall;
	frcm_out_t                   out_data;
	logic                        cfg_valid;
	logic                        cfg_ready;
	logic [FIELD_COORD_BITS-1:0] cfg_data;
	int                          fail_count;
	int                          pending;

	int snd_idle;
	int rcv_idle;
	int n_pixels;
	int n_writes;
	int n_cfg;

	face_region_colour_mask_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	frcm_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial out_stall = 1'b0;
	always @(negedge clk) begin
		if (arst_n)
			out_stall <= ($urandom_range(99) < rcv_idle);
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
			    (cfg_valid && cfg_ready) || !arst_n)
				quiet = 0;
			else
				quiet++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	function automatic frcm_in_t noise_beat();
		frcm_in_t b;
		b.operation   = 1'($urandom);
		b.slot        = SLOT_BITS'($urandom);
		b.rect_left   = FIELD_COORD_BITS'($urandom);
		b.rect_top    = FIELD_COORD_BITS'($urandom);
		b.rect_width  = FIELD_COORD_BITS'($urandom);
		b.rect_height = FIELD_COORD_BITS'($urandom);
		b.entry_valid = 1'($urandom);
		b.pixel_row   = FIELD_COORD_BITS'($urandom);
		b.pixel_col   = FIELD_COORD_BITS'($urandom);
		b.in_blue     = CHAN_BITS'($urandom);
		b.in_green    = CHAN_BITS'($urandom);
		b.in_red      = CHAN_BITS'($urandom);
		return b;
	endfunction

	function automatic frcm_in_t box_beat(int slot, int left, int top, int wid, int hgt,
		logic live);
		frcm_in_t b;
		b             = noise_beat();
		b.operation   = OP_WRITE;
		b.slot        = SLOT_BITS'(slot);
		b.rect_left   = FIELD_COORD_BITS'(left);
		b.rect_top    = FIELD_COORD_BITS'(top);
		b.rect_width  = FIELD_COORD_BITS'(wid);
		b.rect_height = FIELD_COORD_BITS'(hgt);
		b.entry_valid = live;
		return b;
	endfunction

	function automatic frcm_in_t pixel_beat(int row, int col);
		frcm_in_t b;
		b           = noise_beat();
		b.operation = OP_PIXEL;
		b.pixel_row = FIELD_COORD_BITS'(row);
		b.pixel_col = FIELD_COORD_BITS'(col);
		return b;
	endfunction

	function automatic int coord_pick(int lo, int hi);
		if ($urandom_range(99) < 75)
			return $urandom_range(hi, lo);
		return $urandom_range(4095, 0);
	endfunction

	function automatic frcm_in_t random_beat();
		if ($urandom_range(99) < 30)
			return box_beat($urandom_range(7, 0), coord_pick(0, 63), coord_pick(0, 63),
				coord_pick(0, 48), coord_pick(0, 48), $urandom_range(99) < 85);
		return pixel_beat(coord_pick(0, 80), coord_pick(0, 80));
	endfunction

	task automatic send_beat(input frcm_in_t b);
		while ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= b;
		do
			@(posedge clk);
		while (in_stall);
		if (b.operation == OP_PIXEL)
			n_pixels++;
		else
			n_writes++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic set_min_width(input int value);
		drain();
		repeat (4) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= FIELD_COORD_BITS'(value);
		do
			@(posedge clk);
		while (!cfg_ready);
		n_cfg++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		frcm_in_t b;
		int       ph;
		int       i;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		arst_n    = 1'b0;
		snd_idle  = 7;
		rcv_idle  = 48;
		n_pixels  = 0;
		n_writes  = 0;
		n_cfg     = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		b = pixel_beat(0, 0);
		b.in_blue  = '0;
		b.in_green = '0;
		b.in_red   = '0;
		send_beat(b);
		b = pixel_beat(4095, 4095);
		b.in_blue  = '1;
		b.in_green = '1;
		b.in_red   = '1;
		send_beat(b);
		send_beat(box_beat(0, 10, 20, 5, 3, 1'b1));
		send_beat(pixel_beat(20, 10));
		send_beat(pixel_beat(23, 15));
		send_beat(pixel_beat(19, 10));
		send_beat(pixel_beat(20, 16));
		send_beat(pixel_beat(24, 15));
		send_beat(pixel_beat(21, 9));
		send_beat(box_beat(1, 100, 100, 0, 0, 1'b1));
		send_beat(pixel_beat(100, 100));
		send_beat(box_beat(7, 4095, 4090, 4095, 4095, 1'b1));
		send_beat(pixel_beat(4095, 4095));
		send_beat(pixel_beat(4089, 4095));
		send_beat(pixel_beat(4090, 4094));
		send_beat(box_beat(2, 0, 0, 4095, 4095, 1'b0));
		send_beat(pixel_beat(2000, 2000));
		send_beat(box_beat(3, 0, 0, 4095, 4095, 1'b1));
		send_beat(pixel_beat(2000, 2000));
		send_beat(box_beat(3, 0, 0, 4095, 4095, 1'b0));
		send_beat(pixel_beat(2000, 2000));
		set_min_width(4095);
		send_beat(pixel_beat(4095, 4095));
		set_min_width(4);
		send_beat(pixel_beat(21, 12));
		set_min_width(5);
		send_beat(pixel_beat(21, 12));

		for (ph = 0; ph < 3; ph++) begin
			snd_idle = (ph == 0) ? 7 : (ph == 1) ? 48 : 0;
			rcv_idle = (ph == 0) ? 48 : (ph == 1) ? 7 : 0;
			set_min_width((ph == 1) ? 0 : $urandom_range(24, 0));
			for (i = 0; i < PHASE_BEATS; i++) begin
				if (i == 75)
					drain();
				if (i == 155)
					set_min_width($urandom_range(24, 0));
				send_beat(random_beat());
			end
		end

		drain();
		repeat (8) @(negedge clk);
		$display("Sent %0d pixel beats and %0d rectangle writes over %0d min_width settings,",
			n_pixels, n_writes, n_cfg);
		$display("with sender and receiver gaps in turn and then back to back.");
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== face_region_colour_mask_top.f =====
rtl/frcm_pkg.sv
rtl/frcm_rect_table.sv
rtl/frcm_colour.sv
rtl/face_region_colour_mask_top.sv
bench/frcm_checker.sv
bench/tb_top.sv
